// ===== hw/rtl/sgb_pkg.sv =====
// Shared types and constants for the spatial grid binning block.
// No dependencies.
package sgb_pkg;

    localparam int NUM_CELLS       = 256;
    localparam int BUCKET_CAPACITY = 16;
    localparam int COORD_FRAC_BITS = 4;
    localparam int CORNERS_N       = 4;
    localparam int CELL_W          = $clog2(NUM_CELLS);
    localparam int SLOT_W          = $clog2(BUCKET_CAPACITY);
    localparam int COUNT_W         = $clog2(BUCKET_CAPACITY + 1);
    localparam int ID_W            = 10;
    localparam int SIZE_W          = 12;
    localparam int COLS_W          = 9;
    localparam int COORD_W         = 16;
    localparam int HALF_W          = 15;
    localparam int CORNER_W        = 18;
    localparam int DIV_W           = SIZE_W + COORD_FRAC_BITS;
    localparam int QUO_W           = CORNER_W;
    localparam int IDX_W           = 32;
    localparam int QDEPTH          = 4;
    localparam int QPTR_W          = $clog2(QDEPTH);

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_QUERY    = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    localparam logic CFG_CELL_SIZE = 1'b0;
    localparam logic CFG_COLUMNS   = 1'b1;

    // One queued job: a bucket to visit, or a marker for the item's end.
    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   id;
        logic              has_cell;
        logic [CELL_W-1:0] bucket;
        logic              item_end;
    } job_t;

endpackage

// ===== hw/rtl/spatial_grid_binning.sv =====
// Top level of the spatial grid binning block: configuration registers,
// front end, job queue and back end. Uses sgb_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  config   | cfg_we             | cfg_index, cfg_data
//  item in  | start & !busy      | op entity_id center_x/y half_width/height
//  result   | valid (one cycle)  | found_id found overflow last
//
// A register or query item is handled one corner at a time, and each
// corner costs two 18-step serial divisions plus load, index and issue
// states; a query also walks the last bucket entry by entry, while earlier
// walks overlap the divisions. Clear and the unused op go straight to the end.
// Reset clears the bucket fill flags; counts and entries need no clearing.
// The result side cannot stall; busy holds until the item is fully done.
module spatial_grid_binning
    import sgb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [SIZE_W-1:0]         cfg_data,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                op,
    input  logic [ID_W-1:0]           entity_id,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic [HALF_W-1:0]         half_width,
    input  logic [HALF_W-1:0]         half_height,
    output logic                      valid,
    output logic [ID_W-1:0]           found_id,
    output logic                      found,
    output logic                      overflow,
    output logic                      last
);

    logic [SIZE_W-1:0] size_reg;
    logic [COLS_W-1:0] cols_reg;
    logic front_busy, fj_valid, fj_ready, bj_valid, bj_take, back_idle;
    logic accept;
    job_t fj, bj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(32);
            cols_reg <= COLS_W'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CELL_SIZE: size_reg <= cfg_data;
                CFG_COLUMNS:   cols_reg <= cfg_data[COLS_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept = start && !busy;

    sgb_front u_front (
        .clk, .rst_n, .start(accept), .busy(front_busy), .op, .entity_id,
        .center_x, .center_y, .half_width, .half_height,
        .cell_size(size_reg), .grid_columns(cols_reg),
        .job_valid(fj_valid), .job(fj), .job_ready(fj_ready)
    );

    sgb_queue u_queue (
        .clk, .rst_n, .in_valid(fj_valid), .in_job(fj), .in_ready(fj_ready),
        .out_valid(bj_valid), .out_job(bj), .out_take(bj_take)
    );

    sgb_back u_back (
        .clk, .rst_n, .job_valid(bj_valid), .job(bj), .job_take(bj_take),
        .idle(back_idle), .valid, .found_id, .found, .overflow, .last
    );

    assign busy = front_busy || !back_idle || valid;

endmodule

// ===== hw/rtl/sgb_front.sv =====
// Front end: corner generation, floor division by the cell size and
// cell index building with duplicate removal. Uses sgb_pkg.
module sgb_front
    import sgb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                op,
    input  logic [ID_W-1:0]           entity_id,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic [HALF_W-1:0]         half_width,
    input  logic [HALF_W-1:0]         half_height,
    input  logic [SIZE_W-1:0]         cell_size,
    input  logic [COLS_W-1:0]         grid_columns,
    output logic                      job_valid,
    output job_t                      job,
    input  logic                      job_ready
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_DIV  = 6'b000100,
        S_IDX  = 6'b001000,
        S_EMIT = 6'b010000,
        S_END  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]                 op_reg;
    logic [ID_W-1:0]            id_reg;
    logic signed [CORNER_W-1:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic [DIV_W-1:0]           d_reg;
    logic [COLS_W-1:0]          cols_reg;
    logic [1:0]                 corner_reg;
    logic                       axis_reg;   // 0 x, 1 y
    logic [4:0]                 bit_reg;
    logic [CORNER_W-1:0]        mag_reg;
    logic                       neg_reg;
    logic [DIV_W-1:0]           rem_reg;
    logic [QUO_W-1:0]           quo_reg;
    logic signed [QUO_W:0]      qx_reg;
    logic signed [QUO_W:0]      qy_reg;
    logic                       cand_ok_reg;
    logic [CELL_W-1:0]          cand_reg;
    logic [CELL_W-1:0]          taken_reg [CORNERS_N-1:0];
    logic [2:0]                 ntaken_reg;

    logic signed [CORNER_W-1:0] sel_coord;
    logic                       sel_neg;
    logic [CORNER_W-1:0]        sel_abs;
    logic [DIV_W:0]             rem_shift;
    logic [DIV_W:0]             rem_sub;
    logic                       rem_ge;
    logic [QUO_W-1:0]           quo_fin;
    logic [QUO_W:0]             quo_ext;
    logic [QUO_W:0]             quo_up;
    logic signed [QUO_W:0]      q_fin;
    logic signed [IDX_W-1:0]    idx;
    logic                       dup;

    always_comb
    begin
        unique case (corner_reg)
            2'd0: sel_coord = axis_reg ? ymin_reg : xmin_reg;
            2'd1: sel_coord = axis_reg ? ymin_reg : xmax_reg;
            2'd2: sel_coord = axis_reg ? ymax_reg : xmax_reg;
            default: sel_coord = axis_reg ? ymax_reg : xmin_reg;
        endcase
    end

    assign sel_neg = sel_coord[CORNER_W-1];
    assign sel_abs = sel_neg ? CORNER_W'(-sel_coord) : CORNER_W'(sel_coord);

    // restoring division, one quotient bit per cycle
    assign rem_shift = {rem_reg, mag_reg[bit_reg]};
    assign rem_ge    = rem_shift >= {1'b0, d_reg};
    assign rem_sub   = rem_ge ? rem_shift - {1'b0, d_reg} : rem_shift;
    assign quo_fin   = {quo_reg[QUO_W-2:0], rem_ge};

    // floor of a negative dividend: -(q) minus one when the remainder is non-zero
    assign quo_ext = {1'b0, quo_fin};
    assign quo_up  = quo_ext + {{QUO_W{1'b0}}, (rem_sub != '0)};
    assign q_fin   = neg_reg ? -$signed(quo_up) : $signed(quo_ext);

    assign idx = IDX_W'(qx_reg) + IDX_W'(qy_reg) * IDX_W'($signed({1'b0, cols_reg}));

    always_comb
    begin
        dup = 1'b0;
        for (int k = 0; k < CORNERS_N; k++)
            if (3'(k) < ntaken_reg && taken_reg[k] == cand_reg)
                dup = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_REGISTER || op == OP_QUERY)
                        state_next = S_LOAD;
                    else
                        state_next = S_END;
                end
            end
            S_LOAD: state_next = S_DIV;
            S_DIV:
            begin
                if (bit_reg == 5'd0)
                begin
                    if (axis_reg)
                        state_next = S_IDX;
                    else
                        state_next = S_LOAD;
                end
            end
            S_IDX:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (!cand_ok_reg || dup || job_ready)
                begin
                    if (corner_reg == 2'd3)
                        state_next = S_END;
                    else
                        state_next = S_LOAD;
                end
            end
            S_END:  if (job_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg     <= op;
                id_reg     <= entity_id;
                xmin_reg   <= CORNER_W'(center_x) - CORNER_W'(half_width);
                xmax_reg   <= CORNER_W'(center_x) + CORNER_W'(half_width);
                ymin_reg   <= CORNER_W'(center_y) - CORNER_W'(half_height);
                ymax_reg   <= CORNER_W'(center_y) + CORNER_W'(half_height);
                d_reg      <= {((cell_size == '0) ? SIZE_W'(1) : cell_size),
                               {COORD_FRAC_BITS{1'b0}}};
                cols_reg   <= grid_columns;
                corner_reg <= 2'd0;
                axis_reg   <= 1'b0;
                ntaken_reg <= 3'd0;
            end
            S_LOAD:
            begin
                // take the coordinate's magnitude and sign for the next division
                mag_reg <= sel_abs;
                neg_reg <= sel_neg;
                rem_reg <= '0;
                quo_reg <= '0;
                bit_reg <= 5'(CORNER_W - 1);
            end
            S_DIV:
            begin
                rem_reg <= rem_sub[DIV_W-1:0];
                quo_reg <= quo_fin;
                bit_reg <= bit_reg - 5'd1;
                if (bit_reg == 5'd0)
                begin
                    if (axis_reg)
                        qy_reg <= q_fin;
                    else
                        qx_reg <= q_fin;
                    axis_reg <= ~axis_reg;
                end
            end
            S_IDX:
            begin
                cand_ok_reg <= (idx >= 0) && (idx < IDX_W'(NUM_CELLS));
                cand_reg    <= idx[CELL_W-1:0];
            end
            S_EMIT:
            begin
                if (state_next != S_EMIT)
                begin
                    if (cand_ok_reg && !dup)
                    begin
                        taken_reg[ntaken_reg[1:0]] <= cand_reg;
                        ntaken_reg <= ntaken_reg + 3'd1;
                    end
                    corner_reg <= corner_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign job_valid = (state_reg == S_END) ||
                       (state_reg == S_EMIT && cand_ok_reg && !dup);
    always_comb
    begin
        job.op       = op_reg;
        job.id       = id_reg;
        job.has_cell = (state_reg == S_EMIT);
        job.bucket   = cand_reg;
        job.item_end = (state_reg == S_END);
    end

endmodule

// ===== hw/rtl/sgb_queue.sv =====
// Short job queue between front and back ends. Uses sgb_pkg.
module sgb_queue
    import sgb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  job_t in_job,
    output logic in_ready,
    output logic out_valid,
    output job_t out_job,
    input  logic out_take
);

    job_t            mem_reg [QDEPTH-1:0];
    logic [QPTR_W:0] wr_reg, rd_reg;

    assign in_ready  = (wr_reg - rd_reg) != (QPTR_W+1)'(QDEPTH);
    assign out_valid = wr_reg != rd_reg;
    assign out_job   = mem_reg[rd_reg[QPTR_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            mem_reg[wr_reg[QPTR_W-1:0]] <= in_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready) wr_reg <= wr_reg + (QPTR_W+1)'(1);
            if (out_take && out_valid) rd_reg <= rd_reg + (QPTR_W+1)'(1);
        end
    end

endmodule

// ===== hw/rtl/sgb_back.sv =====
// Back end: bucket store, appends, bucket walks and result strobes.
// Uses sgb_pkg.
module sgb_back
    import sgb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  job_t            job,
    output logic            job_take,
    output logic            idle,
    output logic            valid,
    output logic [ID_W-1:0] found_id,
    output logic            found,
    output logic            overflow,
    output logic            last
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_CNT  = 4'b0010,
        B_WALK = 4'b0100,
        B_DATA = 4'b1000
    } bstate_t;

    bstate_t state_reg, state_next;

    logic [ID_W-1:0]    entries [NUM_CELLS*BUCKET_CAPACITY-1:0];
    logic [COUNT_W-1:0] counts [NUM_CELLS-1:0];
    logic [NUM_CELLS-1:0] filled_reg;     // bucket appended to since the last clear

    logic [1:0]           op_reg;
    logic [ID_W-1:0]      id_reg;
    logic                 ovf_reg;
    logic [CELL_W-1:0]    cell_reg;
    logic [COUNT_W-1:0]   cnt_rd_reg;
    logic                 filled_rd_reg;
    logic [COUNT_W-1:0]   slot_reg;
    logic [COUNT_W-1:0]   cnt_reg;
    logic [ID_W-1:0]      rd_data_reg;
    logic                 pend_reg;       // one found entry held back for last
    logic [ID_W-1:0]      pend_id_reg;

    logic                 out_v;
    logic [ID_W-1:0]      out_id;
    logic                 out_f, out_o, out_l;
    logic [COUNT_W-1:0]   cnt_now;
    logic                 full;

    assign cnt_now  = filled_rd_reg ? cnt_rd_reg : '0;
    assign full     = cnt_now >= COUNT_W'(BUCKET_CAPACITY);
    assign job_take = job_valid && (state_reg == B_IDLE);
    assign idle     = (state_reg == B_IDLE) && !job_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (job_take && job.has_cell) state_next = B_CNT;
            B_CNT:
            begin
                if (op_reg == OP_QUERY && cnt_now != '0)
                    state_next = B_WALK;
                else
                    state_next = B_IDLE;
            end
            B_WALK: state_next = B_DATA;
            B_DATA: if (slot_reg == cnt_reg) state_next = B_IDLE; else state_next = B_WALK;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (job_take && job.has_cell)
            cnt_rd_reg <= counts[job.bucket];
        if (state_reg == B_CNT && op_reg == OP_REGISTER && !full)
        begin
            counts[cell_reg] <= cnt_now + COUNT_W'(1);
            entries[{cell_reg, cnt_now[SLOT_W-1:0]}] <= id_reg;
        end
        rd_data_reg <= entries[{cell_reg, slot_reg[SLOT_W-1:0]}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            filled_reg <= '0;
            ovf_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            valid      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid     <= out_v;
            if (state_reg == B_CNT && op_reg == OP_REGISTER)
            begin
                if (full) ovf_reg <= 1'b1;
                else      filled_reg[cell_reg] <= 1'b1;
            end
            if (job_take && job.item_end)
            begin
                ovf_reg  <= 1'b0;
                pend_reg <= 1'b0;
                if (job.op == OP_CLEAR)
                    filled_reg <= '0;
            end
            if (state_reg == B_DATA)
                pend_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            op_reg        <= job.op;
            id_reg        <= job.id;
            cell_reg      <= job.bucket;
            filled_rd_reg <= filled_reg[job.bucket];
        end
        if (state_reg == B_CNT)
        begin
            cnt_reg  <= cnt_now;
            slot_reg <= '0;
        end
        else if (state_reg == B_WALK)
            slot_reg <= slot_reg + COUNT_W'(1);
        if (state_reg == B_DATA)
            pend_id_reg <= rd_data_reg;
    end

    // emit the held entry when a newer one arrives or when the item ends
    always_comb
    begin
        out_v  = 1'b0;
        out_id = '0;
        out_f  = 1'b0;
        out_o  = 1'b0;
        out_l  = 1'b0;
        if (state_reg == B_DATA && pend_reg)
        begin
            out_v  = 1'b1;
            out_id = pend_id_reg;
            out_f  = 1'b1;
        end
        else if (job_take && job.item_end)
        begin
            out_v = 1'b1;
            out_l = 1'b1;
            if (job.op == OP_REGISTER)
                out_o = ovf_reg;
            else if (job.op == OP_QUERY && pend_reg)
            begin
                out_id = pend_id_reg;
                out_f  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_id <= out_id;
        found    <= out_f;
        overflow <= out_o;
        last     <= out_l;
    end

endmodule
